@@ rtl/core/cra_pkg.sv @@
package cra_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int CTRL_W  = 3;
    localparam int ID_W    = 31;
    localparam int MASK_W  = 32;
    localparam int MSEL_W  = 4;
    localparam int MBHIT_W = 5;
    localparam int PHIT_W  = 8;
    localparam int EXT_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_MBOX = 2'd0,
        CMD_WR_PDU  = 2'd1,
        CMD_WR_MASK = 2'd2,
        CMD_LOOKUP  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CTRL_W-1:0] ctrl;
        logic              is_rx;
        logic              is_full;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
    } t_mbox;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [MSEL_W-1:0] msel;
    } t_pdu;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MB_RD  = 7'b0000010,
        S_MB_EV  = 7'b0000100,
        S_PDU_RD = 7'b0001000,
        S_MSK_RD = 7'b0010000,
        S_CMP    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

endpackage

@@ rtl/core/can_rx_acceptance_filter_core.sv @@
// A write leaves the block idle; it is ready again in the next cycle, with no result.
// A lookup reads and evaluates each mailbox in turn, then compares the PDUs of each candidate
// mailbox, and holds its result beat until taken; one compare unit is shared by every PDU checked.
// Synchronous active-low reset empties the mailbox and mask tables at once;
// PDU entries keep no reset state and must be written before they are used.
module can_rx_acceptance_filter_core
    import cra_pkg::*;
#(
    parameter int MAILBOXES   = 16,
    parameter int RX_PDUS     = 256,
    parameter int MASKS       = 16,
    parameter int CONTROLLERS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [CTRL_W-1:0]  i_controller_id,
    input  logic               i_object_is_receive,
    input  logic               i_handle_is_full,
    input  logic [IDX_W-1:0]   i_range_first,
    input  logic [IDX_W-1:0]   i_range_last,
    input  logic [ID_W-1:0]    i_frame_id,
    input  logic [MASK_W-1:0]  i_mask_word,
    input  logic [MSEL_W-1:0]  i_mask_select,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic [MBHIT_W-1:0] o_mailbox_hit,
    output logic [PHIT_W-1:0]  o_pdu_hit
);

    localparam int MB_AW  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int PDU_AW = (RX_PDUS > 1) ? $clog2(RX_PDUS) : 1;
    localparam int MSK_AW = (MASKS > 1) ? $clog2(MASKS) : 1;

    t_mbox              mb_mem [MAILBOXES];
    t_pdu               pdu_mem [RX_PDUS];
    logic [MASK_W-1:0]  mask_mem [MASKS];

    logic [MAILBOXES-1:0] r_mb_vld;
    logic [MASKS-1:0]     r_mask_vld;

    t_state              r_state, n_state;
    logic [MB_AW-1:0]    r_mb_idx, n_mb_idx;
    logic [PDU_AW-1:0]   r_pdu_idx, n_pdu_idx;
    logic [ID_W-1:0]     r_rx;
    logic [CTRL_W-1:0]   r_ctrl;
    t_mbox               r_mb_q;
    logic                r_mb_qv;
    t_pdu                r_pdu_q;
    logic [MASK_W-1:0]   r_mask_q;
    logic                r_mask_ok;
    logic                r_acc, n_acc;
    logic [MBHIT_W-1:0]  r_mbhit, n_mbhit;
    logic [PHIT_W-1:0]   r_pduhit, n_pduhit;

    logic               w_in_acc;
    logic               w_out_acc;
    logic [EXT_W-1:0]   w_idx_ext;
    logic [EXT_W-1:0]   w_msel_ext;
    logic [MSK_AW-1:0]  w_msk_addr;
    logic               w_msk_inr;
    logic [MASK_W-1:0]  w_mask;
    logic [ID_W-1:0]    w_pid_m;
    logic [ID_W-1:0]    w_rx_m;
    logic               w_match;
    logic               w_cand;
    logic               w_first_ok;
    logic               w_last_ok;
    logic               w_mb_last;
    logic               w_pdu_last;
    logic [EXT_W-1:0]   w_mb_ext;
    logic [EXT_W-1:0]   w_pdu_ext;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_idx_ext = EXT_W'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_command == CMD_WR_MBOX && w_idx_ext < EXT_W'(MAILBOXES)) begin
            mb_mem[w_idx_ext[MB_AW-1:0]] <= '{ctrl: i_controller_id,
                                               is_rx: i_object_is_receive,
                                               is_full: i_handle_is_full,
                                               first: i_range_first,
                                               last: i_range_last};
        end
        if (w_in_acc && i_command == CMD_WR_PDU && w_idx_ext < EXT_W'(RX_PDUS)) begin
            pdu_mem[w_idx_ext[PDU_AW-1:0]] <= '{id: i_frame_id, msel: i_mask_select};
        end
        if (w_in_acc && i_command == CMD_WR_MASK && w_idx_ext < EXT_W'(MASKS)) begin
            mask_mem[w_idx_ext[MSK_AW-1:0]] <= i_mask_word;
        end
        r_mb_q    <= mb_mem[r_mb_idx];
        r_mb_qv   <= r_mb_vld[r_mb_idx];
        r_pdu_q   <= pdu_mem[r_pdu_idx];
        r_mask_q  <= mask_mem[w_msk_addr];
        r_mask_ok <= w_msk_inr && r_mask_vld[w_msk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mb_vld   <= '0;
            r_mask_vld <= '0;
        end else begin
            if (w_in_acc && i_command == CMD_WR_MBOX && w_idx_ext < EXT_W'(MAILBOXES)) begin
                r_mb_vld[w_idx_ext[MB_AW-1:0]] <= 1'b1;
            end
            if (w_in_acc && i_command == CMD_WR_MASK && w_idx_ext < EXT_W'(MASKS)) begin
                r_mask_vld[w_idx_ext[MSK_AW-1:0]] <= 1'b1;
            end
        end
    end

    assign w_msel_ext = EXT_W'(r_pdu_q.msel);
    assign w_msk_inr  = w_msel_ext < EXT_W'(MASKS);
    assign w_msk_addr = w_msel_ext[MSK_AW-1:0];
    assign w_mask     = r_mask_ok ? r_mask_q : '0;

    assign w_pid_m = r_pdu_q.id & w_mask[ID_W-1:0];
    assign w_rx_m  = r_rx & w_mask[ID_W-1:0];
    assign w_match = r_mb_q.is_full ? (r_rx == w_pid_m) : (w_rx_m == w_pid_m);

    assign w_cand     = r_mb_qv && r_mb_q.is_rx && r_mb_q.ctrl == r_ctrl;
    assign w_first_ok = EXT_W'(r_mb_q.first) < EXT_W'(RX_PDUS);
    assign w_last_ok  = EXT_W'(r_mb_q.last) < EXT_W'(RX_PDUS) && r_mb_q.first <= r_mb_q.last;
    assign w_mb_last  = r_mb_idx == MB_AW'(MAILBOXES - 1);
    assign w_mb_ext   = EXT_W'(r_mb_idx);
    assign w_pdu_ext  = EXT_W'(r_pdu_idx);
    assign w_pdu_last = w_pdu_ext == EXT_W'(r_mb_q.last);

    always_comb begin
        n_state   = r_state;
        n_mb_idx  = r_mb_idx;
        n_pdu_idx = r_pdu_idx;
        n_acc     = r_acc;
        n_mbhit   = r_mbhit;
        n_pduhit  = r_pduhit;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_command == CMD_LOOKUP) begin
                    n_mb_idx = '0;
                    n_acc    = 1'b0;
                    n_mbhit  = MBHIT_W'(MAILBOXES);
                    n_pduhit = '0;
                    if (EXT_W'(i_controller_id) < EXT_W'(CONTROLLERS)) begin
                        n_state = S_MB_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MB_RD: begin
                n_state = S_MB_EV;
            end
            S_MB_EV: begin
                if (w_cand && w_first_ok && (r_mb_q.is_full || w_last_ok)) begin
                    n_pdu_idx = PDU_AW'(r_mb_q.first);
                    n_state   = S_PDU_RD;
                end else if (w_mb_last) begin
                    n_state = S_DONE;
                end else begin
                    n_mb_idx = MB_AW'(r_mb_idx + 1'b1);
                    n_state  = S_MB_RD;
                end
            end
            S_PDU_RD: begin
                n_state = S_MSK_RD;
            end
            S_MSK_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match) begin
                    n_acc    = 1'b1;
                    n_mbhit  = w_mb_ext[MBHIT_W-1:0];
                    n_pduhit = w_pdu_ext[PHIT_W-1:0];
                    n_state  = S_DONE;
                end else if (!r_mb_q.is_full && !w_pdu_last) begin
                    n_pdu_idx = PDU_AW'(r_pdu_idx + 1'b1);
                    n_state   = S_PDU_RD;
                end else if (w_mb_last) begin
                    n_state = S_DONE;
                end else begin
                    n_mb_idx = MB_AW'(r_mb_idx + 1'b1);
                    n_state  = S_MB_RD;
                end
            end
            S_DONE: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mb_idx  <= '0;
            r_pdu_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_mb_idx  <= n_mb_idx;
            r_pdu_idx <= n_pdu_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mbhit  <= n_mbhit;
        r_pduhit <= n_pduhit;
        if (w_in_acc && i_command == CMD_LOOKUP) begin
            r_rx   <= {1'b0, i_frame_id[ID_W-2:0]};
            r_ctrl <= i_controller_id;
        end
    end

    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_state == S_DONE;
    assign o_accepted    = r_acc;
    assign o_mailbox_hit = r_mbhit;
    assign o_pdu_hit     = r_pduhit;

`ifndef ASSERT_OFF
    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("A result beat is pending while new input is taken.");

    a_lookup_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command == CMD_LOOKUP) |=> o_in_stall)
        else $error("A lookup did not occupy the block.");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command != CMD_LOOKUP) |=> (!o_in_stall && !o_out_valid))
        else $error("A table write started a lookup.");

    a_reject_zero_pdu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_pdu_hit == '0))
        else $error("A rejected frame reports a PDU index.");
`endif

endmodule
